// ===== sv/page_best_fit_allocator_macros.svh =====
// Assertion macros shared by the allocator RTL.
`ifndef PAGE_BEST_FIT_ALLOCATOR_MACROS_SVH
`define PAGE_BEST_FIT_ALLOCATOR_MACROS_SVH

// Same-cycle implication, sampled on the rising clock while out of reset.
`define PBFA_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on the rising clock while out of reset.
`define PBFA_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== sv/pbfa_pkg.sv =====
`timescale 1ns / 1ps

package pbfa_pkg;

  typedef enum logic {
    FUNC_ALLOC = 1'b0,
    FUNC_FREE  = 1'b1
  } func_e;

  typedef enum logic [1:0] {
    ST_DONE = 2'd0,
    ST_OOM  = 2'd1,
    ST_BAD  = 2'd2
  } status_e;

  typedef enum logic [3:0] {
    S_CLEAR,
    S_IDLE,
    S_WALK,
    S_A_DECIDE,
    S_A_SPLIT,
    S_F_SIZE,
    S_F_NEXT,
    S_F_COMMIT,
    S_F_NX,
    S_F_PREV,
    S_REPORT
  } state_e;

  localparam int unsigned ADDR_W  = 20;
  localparam int unsigned BYTES_W = 21;

endpackage

// ===== sv/pbfa_pages_ram.sv =====
`timescale 1ns / 1ps

module pbfa_pages_ram #(
  parameter int unsigned DEPTH = 256,
  parameter int unsigned AW    = 8,
  parameter int unsigned DW    = 9
) (
  input  logic          clk_i,
  input  logic          rd_en_i,
  input  logic [AW-1:0] rd_addr_i,
  output logic [DW-1:0] rd_data_o,
  input  logic          wr_en_i,
  input  logic [AW-1:0] wr_addr_i,
  input  logic [DW-1:0] wr_data_i
);

  logic [DW-1:0] mem [DEPTH];
  logic [DW-1:0] rd_data_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem[wr_addr_i] <= wr_data_i;
    end
    if (rd_en_i) begin
      rd_data_q <= mem[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

// ===== sv/page_best_fit_allocator.sv =====
`timescale 1ns / 1ps

// Page-granular best-fit heap allocator with coalescing. Pulse start with busy low to hand
// in one item: func_i selects allocate or free. Exactly one result follows, shown for one
// cycle while done_o is high; the receiver cannot hold it off, so it must take it then.
// Every page has one entry in a synchronous RAM holding a chunk-start flag, a used flag and
// the chunk length. The heap is walked as a linked chain, one chunk per cycle, since the
// next chunk's address is the current one plus its length. After reset the block stays
// busy for a clearing pass that zeroes every entry. An allocate walks every chunk in the
// heap (at most POOL_PAGES chunks) and takes one more step when a chunk is split. A free
// walks every chunk that lies below the freed one, takes one more step when a chunk
// follows it below the break, and one more for each neighbor that it merges with. An
// oversize request or a free address that is misaligned or past the break finishes
// without a RAM read; a free of a page that is not a used chunk ends once its entry is
// read. The item is busy for that whole time and the next one is taken once busy falls,
// which is also the cycle in which done_o shows the previous result.

module page_best_fit_allocator
  import pbfa_pkg::*;
#(
  parameter int unsigned PAGE_BYTES   = 4096,
  parameter int unsigned HEADER_BYTES = 24,
  parameter int unsigned POOL_PAGES   = 256
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start,
  output logic                busy,
  input  logic                func_i,
  input  logic [BYTES_W-1:0]  request_bytes_i,
  input  logic [ADDR_W-1:0]   free_address_i,
  output logic                done_o,
  output logic [ADDR_W-1:0]   result_address_o,
  output logic [1:0]          status_o
);

`include "page_best_fit_allocator_macros.svh"

  // Page index width and page count width (a count may equal the pool size).
  localparam int unsigned AW = (POOL_PAGES > 1) ? $clog2(POOL_PAGES) : 1;
  localparam int unsigned PW = $clog2(POOL_PAGES + 1);
  localparam int unsigned SW = PW + 1;
  // RAM entry: chunk-start flag, used flag, chunk length.
  localparam int unsigned DW = PW + 2;
  // Width of the rounded request sum.
  localparam int unsigned NW = BYTES_W + 1;
  localparam int unsigned XW = (AW + 17 > ADDR_W) ? AW + 17 : ADDR_W;
  localparam int unsigned PSH = $clog2(PAGE_BYTES);

  state_e state_q, state_d;

  logic [PW-1:0]         heap_end_q, heap_end_d;
  logic [AW-1:0]         clr_q, clr_d;

  logic                  func_q, func_d;
  logic [PW-1:0]         need_q, need_d;
  logic [AW-1:0]         fp_q, fp_d;
  logic [PW-1:0]         size_q, size_d;
  logic                  nm_q, nm_d;
  logic [AW-1:0]         nx_q, nx_d;
  logic [AW-1:0]         cur_q, cur_d;
  logic [PW-1:0]         lim_q, lim_d;
  logic [AW-1:0]         prev_q, prev_d;
  logic [PW-1:0]         prev_n_q, prev_n_d;
  logic                  prev_free_q, prev_free_d;
  logic                  have_prev_q, have_prev_d;
  logic                  found_q, found_d;
  logic [AW-1:0]         best_q, best_d;
  logic [PW-1:0]         best_n_q, best_n_d;
  logic                  split_q, split_d;
  logic [AW-1:0]         split_p_q, split_p_d;
  logic [PW-1:0]         split_n_q, split_n_d;
  logic                  drop_q, drop_d;
  logic [ADDR_W-1:0]     res_addr_q, res_addr_d;
  status_e               status_q, status_d;
  logic                  done_q, done_d;

  logic                  rd_en;
  logic [AW-1:0]         rd_addr;
  logic [DW-1:0]         rd_data;
  logic                  wr_en;
  logic [AW-1:0]         wr_addr;
  logic [DW-1:0]         wr_data;

  logic                  rd_start;
  logic                  rd_used;
  logic [PW-1:0]         rd_pages;

  logic                  accept;
  logic [NW-1:0]         need_sum;
  logic [NW-1:0]         need_full;
  logic                  need_oom;
  logic [ADDR_W-1:0]     free_off;
  logic [ADDR_W-1:0]     free_pg;
  logic                  free_bad;

  // Decision terms for the allocate commit.
  logic [AW-1:0]         alloc_page;
  logic [XW-1:0]         alloc_byte;
  logic [SW-1:0]         end_plus_need;
  logic [SW-1:0]         last_plus_need;
  logic [SW-1:0]         walk_next;
  logic [SW-1:0]         nx_sum;

  // Decision terms for the free commit.
  logic                  pm;
  logic [AW-1:0]         new_p;
  logic [PW-1:0]         new_sz;
  logic [SW-1:0]         new_end;

  assign accept = start && !busy;

  assign rd_start = rd_data[PW+1];
  assign rd_used  = rd_data[PW];
  assign rd_pages = rd_data[PW-1:0];

  // Pages needed: round the request plus its header up to whole pages.
  assign need_sum  = NW'(request_bytes_i) + NW'(HEADER_BYTES) + NW'(PAGE_BYTES - 1);
  assign need_full = need_sum >> PSH;
  assign need_oom  = need_full > NW'(POOL_PAGES);

  // A free must name a page-aligned spot below the break; whether a used chunk starts
  // there is read from the RAM in the next cycle.
  assign free_off = free_address_i - ADDR_W'(HEADER_BYTES);
  assign free_pg  = free_off >> PSH;
  always_comb begin
    free_bad = 1'b0;
    if (free_address_i < ADDR_W'(HEADER_BYTES)) begin
      free_bad = 1'b1;
    end else if ((free_off & ADDR_W'(PAGE_BYTES - 1)) != '0) begin
      free_bad = 1'b1;
    end else if (free_pg >= ADDR_W'(heap_end_q)) begin
      free_bad = 1'b1;
    end
  end

  assign walk_next      = SW'(cur_q) + SW'(rd_pages);
  assign nx_sum         = SW'(fp_q) + SW'(rd_pages);
  assign end_plus_need  = SW'(heap_end_q) + SW'(need_q);
  assign last_plus_need = SW'(prev_q) + SW'(need_q);
  assign alloc_byte     = XW'(alloc_page) * XW'(PAGE_BYTES) + XW'(HEADER_BYTES);

  // Merge with the previous chunk when it exists and is free.
  assign pm      = have_prev_q && prev_free_q;
  assign new_p   = pm ? prev_q : fp_q;
  assign new_sz  = pm ? PW'(SW'(prev_n_q) + SW'(size_q)) : size_q;
  assign new_end = SW'(new_p) + SW'(new_sz);

  // Chosen page for an allocate; the empty heap starts at page zero.
  always_comb begin
    if (heap_end_q == '0) begin
      alloc_page = '0;
    end else if (found_q) begin
      alloc_page = best_q;
    end else if (!prev_free_q) begin
      alloc_page = heap_end_q[AW-1:0];
    end else begin
      alloc_page = prev_q;
    end
  end

  // Next state.
  always_comb begin
    state_d = state_q;
    case (state_q)
      S_CLEAR: begin
        if (clr_q == AW'(POOL_PAGES - 1)) begin
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        if (accept) begin
          if (func_i == FUNC_FREE) begin
            state_d = free_bad ? S_REPORT : S_F_SIZE;
          end else if (need_oom) begin
            state_d = S_REPORT;
          end else begin
            state_d = (heap_end_q == '0) ? S_A_DECIDE : S_WALK;
          end
        end
      end
      S_WALK: begin
        if (walk_next >= SW'(lim_q)) begin
          state_d = (func_q == FUNC_FREE) ? S_F_COMMIT : S_A_DECIDE;
        end
      end
      S_F_SIZE: begin
        if (!rd_start || !rd_used) begin
          state_d = S_REPORT;
        end else if (nx_sum < SW'(heap_end_q)) begin
          state_d = S_F_NEXT;
        end else begin
          state_d = (fp_q == '0) ? S_F_COMMIT : S_WALK;
        end
      end
      S_F_NEXT: begin
        state_d = (fp_q == '0) ? S_F_COMMIT : S_WALK;
      end
      S_A_DECIDE: begin
        state_d = S_REPORT;
        if (heap_end_q != '0) begin
          if (found_q) begin
            if (best_n_q > need_q) begin
              state_d = S_A_SPLIT;
            end
          end else if (prev_free_q && prev_n_q > need_q) begin
            state_d = S_A_SPLIT;
          end
        end
      end
      S_A_SPLIT:  state_d = S_REPORT;
      S_F_COMMIT: begin
        if (nm_q) begin
          state_d = S_F_NX;
        end else if (pm) begin
          state_d = S_F_PREV;
        end else begin
          state_d = S_REPORT;
        end
      end
      S_F_NX:     state_d = pm ? S_F_PREV : S_REPORT;
      S_F_PREV:   state_d = S_REPORT;
      S_REPORT:   state_d = S_IDLE;
      default:    state_d = S_IDLE;
    endcase
  end

  // Datapath and memory ports.
  always_comb begin
    heap_end_d  = heap_end_q;
    clr_d       = clr_q;
    func_d      = func_q;
    need_d      = need_q;
    fp_d        = fp_q;
    size_d      = size_q;
    nm_d        = nm_q;
    nx_d        = nx_q;
    cur_d       = cur_q;
    lim_d       = lim_q;
    prev_d      = prev_q;
    prev_n_d    = prev_n_q;
    prev_free_d = prev_free_q;
    have_prev_d = have_prev_q;
    found_d     = found_q;
    best_d      = best_q;
    best_n_d    = best_n_q;
    split_d     = split_q;
    split_p_d   = split_p_q;
    split_n_d   = split_n_q;
    drop_d      = drop_q;
    res_addr_d  = res_addr_q;
    status_d    = status_q;
    done_d      = 1'b0;
    rd_en       = 1'b0;
    rd_addr     = '0;
    wr_en       = 1'b0;
    wr_addr     = '0;
    wr_data     = '0;

    case (state_q)
      // Zero every entry once after reset, so no page reads as a chunk start.
      S_CLEAR: begin
        wr_en   = 1'b1;
        wr_addr = clr_q;
        clr_d   = clr_q + 1'b1;
      end

      S_IDLE: begin
        if (accept) begin
          func_d      = func_i;
          res_addr_d  = '0;
          status_d    = ST_DONE;
          have_prev_d = 1'b0;
          found_d     = 1'b0;
          nm_d        = 1'b0;
          cur_d       = '0;
          if (func_i == FUNC_FREE) begin
            if (free_bad) begin
              status_d = ST_BAD;
            end else begin
              fp_d    = free_pg[AW-1:0];
              lim_d   = PW'(free_pg[AW-1:0]);
              rd_en   = 1'b1;
              rd_addr = free_pg[AW-1:0];
            end
          end else if (need_oom) begin
            status_d = ST_OOM;
          end else begin
            need_d = PW'(need_full);
            lim_d  = heap_end_q;
            if (heap_end_q != '0) begin
              rd_en   = 1'b1;
              rd_addr = '0;
            end
          end
        end
      end

      // One chunk per cycle: the length just read gives the next chunk's start.
      S_WALK: begin
        // The chunk seen before this one is known not to be the last.
        if (func_q == FUNC_ALLOC && have_prev_q && prev_free_q && prev_n_q >= need_q
            && (!found_q || prev_n_q < best_n_q)) begin
          found_d  = 1'b1;
          best_d   = prev_q;
          best_n_d = prev_n_q;
        end
        prev_d      = cur_q;
        prev_n_d    = rd_pages;
        prev_free_d = !rd_used;
        have_prev_d = 1'b1;
        if (walk_next < SW'(lim_q)) begin
          cur_d   = walk_next[AW-1:0];
          rd_en   = 1'b1;
          rd_addr = walk_next[AW-1:0];
        end
      end

      // The freed page must start a used chunk; then look at the chunk after it.
      S_F_SIZE: begin
        if (!rd_start || !rd_used) begin
          status_d = ST_BAD;
        end else begin
          size_d = rd_pages;
          nx_d   = nx_sum[AW-1:0];
          if (nx_sum < SW'(heap_end_q)) begin
            rd_en   = 1'b1;
            rd_addr = nx_sum[AW-1:0];
          end else if (fp_q != '0) begin
            rd_en   = 1'b1;
            rd_addr = '0;
          end
        end
      end

      S_F_NEXT: begin
        if (rd_start && !rd_used) begin
          nm_d   = 1'b1;
          size_d = PW'(SW'(size_q) + SW'(rd_pages));
        end
        if (fp_q != '0) begin
          rd_en   = 1'b1;
          rd_addr = '0;
        end
      end

      S_A_DECIDE: begin
        split_d = 1'b0;
        if (heap_end_q == '0) begin
          heap_end_d = need_q;
        end else if (found_q) begin
          if (best_n_q > need_q) begin
            split_d   = 1'b1;
            split_p_d = AW'(SW'(best_q) + SW'(need_q));
            split_n_d = best_n_q - need_q;
          end
        end else if (!prev_free_q) begin
          if (end_plus_need > SW'(POOL_PAGES)) begin
            status_d = ST_OOM;
          end else begin
            heap_end_d = PW'(end_plus_need);
          end
        end else if (prev_n_q < need_q) begin
          if (last_plus_need > SW'(POOL_PAGES)) begin
            status_d = ST_OOM;
          end else begin
            heap_end_d = PW'(last_plus_need);
          end
        end else if (prev_n_q > need_q) begin
          split_d   = 1'b1;
          split_p_d = AW'(last_plus_need);
          split_n_d = prev_n_q - need_q;
        end

        // The out-of-memory cases above leave the heap untouched.
        if (!((heap_end_q != '0) && !found_q
              && ((!prev_free_q && end_plus_need > SW'(POOL_PAGES))
                  || (prev_free_q && prev_n_q < need_q
                      && last_plus_need > SW'(POOL_PAGES))))) begin
          wr_en      = 1'b1;
          wr_addr    = alloc_page;
          wr_data    = {1'b1, 1'b1, need_q};
          res_addr_d = alloc_byte[ADDR_W-1:0];
        end
      end

      S_A_SPLIT: begin
        wr_en   = 1'b1;
        wr_addr = split_p_q;
        wr_data = {1'b1, 1'b0, split_n_q};
      end

      // The freed chunk keeps its start only when it neither joins the previous chunk nor
      // reaches the break. A free chunk that reaches the break is dropped.
      S_F_COMMIT: begin
        drop_d  = (new_end >= SW'(heap_end_q));
        wr_en   = 1'b1;
        wr_addr = fp_q;
        wr_data = {!(pm || new_end >= SW'(heap_end_q)), 1'b0, size_q};
        if (new_end >= SW'(heap_end_q)) begin
          heap_end_d = PW'(new_p);
        end
      end

      // The following chunk was merged in and no longer starts a chunk.
      S_F_NX: begin
        wr_en   = 1'b1;
        wr_addr = nx_q;
        wr_data = '0;
      end

      S_F_PREV: begin
        wr_en   = 1'b1;
        wr_addr = prev_q;
        wr_data = {!drop_q, 1'b0, new_sz};
      end

      S_REPORT: begin
        done_d = 1'b1;
      end

      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= S_CLEAR;
      heap_end_q <= '0;
      clr_q      <= '0;
      done_q     <= 1'b0;
    end else begin
      state_q    <= state_d;
      heap_end_q <= heap_end_d;
      clr_q      <= clr_d;
      done_q     <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    func_q      <= func_d;
    need_q      <= need_d;
    fp_q        <= fp_d;
    size_q      <= size_d;
    nm_q        <= nm_d;
    nx_q        <= nx_d;
    cur_q       <= cur_d;
    lim_q       <= lim_d;
    prev_q      <= prev_d;
    prev_n_q    <= prev_n_d;
    prev_free_q <= prev_free_d;
    have_prev_q <= have_prev_d;
    found_q     <= found_d;
    best_q      <= best_d;
    best_n_q    <= best_n_d;
    split_q     <= split_d;
    split_p_q   <= split_p_d;
    split_n_q   <= split_n_d;
    drop_q      <= drop_d;
    res_addr_q  <= res_addr_d;
    status_q    <= status_d;
  end

  pbfa_pages_ram #(
    .DEPTH (POOL_PAGES),
    .AW    (AW),
    .DW    (DW)
  ) u_pages_ram (
    .clk_i     (clk_i),
    .rd_en_i   (rd_en),
    .rd_addr_i (rd_addr),
    .rd_data_o (rd_data),
    .wr_en_i   (wr_en),
    .wr_addr_i (wr_addr),
    .wr_data_i (wr_data)
  );

  assign busy             = (state_q != S_IDLE);
  assign done_o           = done_q;
  assign result_address_o = res_addr_q;
  assign status_o         = status_q;

  // A split is only queued when a chunk was handed out successfully.
  `PBFA_ASSERT_IMPL(a_split_ok, state_q == S_A_SPLIT, status_q == ST_DONE && split_q, "split without a successful allocate")
  // Failed requests never report an address.
  `PBFA_ASSERT_IMPL(a_fail_zero, done_o && status_o != ST_DONE, result_address_o == '0, "address reported on a failed request")
  // The break never passes the pool.
  `PBFA_ASSERT_IMPL(a_break_range, 1'b1, heap_end_q <= PW'(POOL_PAGES), "break beyond the pool")
  // An accepted item always makes the block busy in the next cycle.
  `PBFA_ASSERT_NEXT(a_accept_busy, accept, busy && !done_o, "accepted item did not start")

endmodule

// ===== test/alloc_checker.sv =====
`timescale 1ns / 1ps

module alloc_checker
  import pbfa_pkg::*;
#(
  parameter int unsigned PAGE_BYTES   = 4096,
  parameter int unsigned HEADER_BYTES = 24,
  parameter int unsigned POOL_PAGES   = 256
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start,
  input  logic               busy,
  input  logic               func_i,
  input  logic [BYTES_W-1:0] request_bytes_i,
  input  logic [ADDR_W-1:0]  free_address_i,
  input  logic               done_o,
  input  logic [ADDR_W-1:0]  result_address_o,
  input  logic [1:0]         status_o,
  output int                 fail_count,
  output int                 pending_count,
  output logic               activity
);

  typedef struct packed {
    logic [ADDR_W-1:0] addr;
    status_e           status;
  } alloc_result_t;

  // Shadow copy of the heap tables.
  bit heads[POOL_PAGES];
  bit taken[POOL_PAGES];
  int span[POOL_PAGES];
  int brk;

  alloc_result_t awaited[$];

  function automatic void wipe_heap();
    for (int i = 0; i < POOL_PAGES; i++) begin
      heads[i] = 0;
      taken[i] = 0;
      span[i]  = 0;
    end
    brk = 0;
  endfunction

  function automatic void place(int p, int n, bit u);
    heads[p] = 1;
    taken[p] = u;
    span[p]  = n;
  endfunction

  function automatic logic [ADDR_W-1:0] addr_at(int p);
    longint v;
    v = longint'(p) * PAGE_BYTES + HEADER_BYTES;
    return v[ADDR_W-1:0];
  endfunction

  function automatic int tail_chunk();
    int p;
    int t;
    p = 0;
    t = brk;
    while (p < brk && p < POOL_PAGES && span[p] != 0) begin
      t = p;
      p += span[p];
    end
    return t;
  endfunction

  function automatic alloc_result_t place_request(int bytes);
    alloc_result_t r;
    int need;
    int p;
    int best;
    int t;
    int n;
    bit hit;
    r = '{addr: '0, status: ST_OOM};
    need = (bytes + HEADER_BYTES + PAGE_BYTES - 1) / PAGE_BYTES;
    if (need == 0) need = 1;
    if (need > POOL_PAGES) return r;
    t = tail_chunk();
    best = 0;
    hit = 0;
    p = 0;
    while (p < brk && p < POOL_PAGES && span[p] != 0) begin
      n = span[p];
      if (p != t && !taken[p] && n >= need && (!hit || n < span[best])) begin
        best = p;
        hit = 1;
      end
      p += n;
    end
    if (hit) begin
      n = span[best];
      if (n > need) place(best + need, n - need, 0);
      place(best, need, 1);
      return '{addr: addr_at(best), status: ST_DONE};
    end
    if (brk == 0) begin
      place(0, need, 1);
      brk = need;
      return '{addr: addr_at(0), status: ST_DONE};
    end
    if (t >= POOL_PAGES) return r;
    if (taken[t]) begin
      if (brk + need > POOL_PAGES) return r;
      p = brk;
      place(p, need, 1);
      brk = p + need;
      return '{addr: addr_at(p), status: ST_DONE};
    end
    n = span[t];
    if (n < need) begin
      if (t + need > POOL_PAGES) return r;
      brk = t + need;
    end else if (n > need) begin
      place(t + need, n - need, 0);
    end
    place(t, need, 1);
    return '{addr: addr_at(t), status: ST_DONE};
  endfunction

  function automatic alloc_result_t release_chunk(int a);
    alloc_result_t r;
    int off;
    int p;
    int size;
    int nx;
    int q;
    r = '{addr: '0, status: ST_BAD};
    if (a < HEADER_BYTES) return r;
    off = a - HEADER_BYTES;
    if (off % PAGE_BYTES != 0) return r;
    p = off / PAGE_BYTES;
    if (p >= brk || p >= POOL_PAGES) return r;
    if (!heads[p] || !taken[p]) return r;
    r.status = ST_DONE;
    taken[p] = 0;
    size = span[p];
    nx = p + size;
    if (nx < brk && nx < POOL_PAGES && heads[nx] && !taken[nx]) begin
      size += span[nx];
      heads[nx] = 0;
      span[p] = size;
    end
    q = 0;
    while (q < p && span[q] != 0) begin
      if (q + span[q] == p) begin
        if (!taken[q]) begin
          span[q] += size;
          size = span[q];
          heads[p] = 0;
          p = q;
        end
        break;
      end
      q += span[q];
    end
    if (p + size >= brk) begin
      heads[p] = 0;
      brk = p;
    end
    if (brk == 0) wipe_heap();
    return r;
  endfunction

  assign pending_count = awaited.size();

  always @(posedge clk_i or negedge rst_ni) begin
    alloc_result_t got;
    alloc_result_t want;
    int errs;
    if (!rst_ni) begin
      wipe_heap();
      awaited.delete();
      fail_count <= 0;
      activity <= 1'b0;
    end else begin
      errs = 0;
      activity <= done_o || (start && !busy);
      if (done_o) begin
        got = '{addr: result_address_o, status: status_e'(status_o)};
        if (awaited.size() == 0) begin
          $display("%0t: result with nothing expected: addr %h status %0d", $time,
                   got.addr, got.status);
          errs++;
        end else begin
          want = awaited.pop_front();
          if (got.addr !== want.addr) begin
            $display("%0t: address expected %h actual %h", $time, want.addr, got.addr);
            errs++;
          end
          if (got.status !== want.status) begin
            $display("%0t: status expected %0d actual %0d", $time, want.status, got.status);
            errs++;
          end
        end
      end
      fail_count <= fail_count + errs;
      if (start && !busy) begin
        if (func_i == FUNC_ALLOC) awaited.push_back(place_request(int'(request_bytes_i)));
        else awaited.push_back(release_chunk(int'(free_address_i)));
      end
    end
  end

endmodule

// ===== test/testbench.sv =====
`timescale 1ns / 1ps

// Stimulus and verdict for the page allocator. The checker beside the block keeps its
// own copy of the heap, predicts every result and counts mismatches; this module only
// feeds requests and decides pass or fail at the end.
module testbench;
  import pbfa_pkg::*;

  localparam int WATCHDOG_CYCLES = 5000;

  logic               clk_i = 1'b0;
  logic               rst_ni = 1'b0;
  logic               start = 1'b0;
  logic               busy;
  logic               func_i = FUNC_ALLOC;
  logic [BYTES_W-1:0] request_bytes_i = '0;
  logic [ADDR_W-1:0]  free_address_i = '0;
  logic               done_o;
  logic [ADDR_W-1:0]  result_address_o;
  logic [1:0]         status_o;
  int                 fail_count;
  int                 pending_count;
  logic               activity;
  int                 quiet_cycles = 0;

  // Addresses handed out and not yet given back; frees draw from here so that most
  // free items name a live chunk.
  logic [ADDR_W-1:0] live_chunks[$];

  always #5 clk_i = ~clk_i;

  page_best_fit_allocator dut (
    .clk_i, .rst_ni, .start, .busy, .func_i, .request_bytes_i, .free_address_i,
    .done_o, .result_address_o, .status_o
  );

  alloc_checker checker_i (
    .clk_i, .rst_ni, .start, .busy, .func_i, .request_bytes_i, .free_address_i,
    .done_o, .result_address_o, .status_o, .fail_count, .pending_count, .activity
  );

  // A successful allocate is the only kind of item that returns a nonzero address.
  always @(posedge clk_i) begin
    if (done_o && status_o == ST_DONE && result_address_o != '0)
      live_chunks.push_back(result_address_o);
  end

  // The watchdog ends the run when nothing has been accepted or returned for too long.
  always @(posedge clk_i) begin
    if (activity) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WATCHDOG_CYCLES) begin
      $display("FAIL");
      $finish;
    end
  end

  // Presents one item at the current rising edge and returns at the edge that accepts it.
  // Busy only moves on rising edges, so sampling it on the falling edge tells whether the
  // coming edge will take the item. Start is left high; the caller lowers it for a gap.
  task automatic issue(input func_e f, input int bytes, input int addr);
    start           <= 1'b1;
    func_i          <= f;
    request_bytes_i <= bytes[BYTES_W-1:0];
    free_address_i  <= addr[ADDR_W-1:0];
    forever begin
      @(negedge clk_i);
      if (!busy) break;
    end
    @(posedge clk_i);
  endtask

  // Mostly back-to-back items, some short gaps and a few long ones.
  task automatic idle_gap();
    int pick;
    int cycles;
    pick = $urandom_range(99);
    cycles = pick < 60 ? 0 : pick < 92 ? $urandom_range(3, 1) : $urandom_range(60, 10);
    if (cycles > 0) begin
      start <= 1'b0;
      repeat (cycles) @(posedge clk_i);
    end
  endtask

  // Holds off until every awaited result is back.
  task automatic drain();
    start <= 1'b0;
    @(posedge clk_i);
    while (pending_count != 0) @(posedge clk_i);
    @(posedge clk_i);
  endtask

  function automatic int take_live();
    int idx;
    logic [ADDR_W-1:0] a;
    idx = $urandom_range(live_chunks.size() - 1);
    a = live_chunks[idx];
    live_chunks.delete(idx);
    return int'(a);
  endfunction

  function automatic int random_size();
    int pick;
    pick = $urandom_range(99);
    if (pick < 70) return $urandom_range(20000);
    if (pick < 95) return $urandom_range(120000);
    if (pick < 98) return $urandom_range(1048576);
    return $urandom_range(2097151, 1048577);
  endfunction

  initial begin
    int pick;
    int held;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed part: size extremes, page boundaries, bad frees, a double free, and a
    // single request that fills the whole pool. Each item runs alone.
    issue(FUNC_ALLOC, 0, 0);                  drain();
    issue(FUNC_ALLOC, 4072, 0);               drain();
    issue(FUNC_ALLOC, 4073, 0);               drain();
    issue(FUNC_ALLOC, 1048576, 0);            drain();
    issue(FUNC_ALLOC, 2097151, 0);            drain();
    issue(FUNC_FREE, 0, 0);                   drain();
    issue(FUNC_FREE, 0, 25);                  drain();
    issue(FUNC_FREE, 0, 1048575);             drain();
    issue(FUNC_FREE, 0, 4096 * 200 + 24);     drain();
    issue(FUNC_FREE, 0, 4096 + 24);           drain();
    held = take_live();
    issue(FUNC_FREE, 0, held);                drain();
    issue(FUNC_FREE, 0, held);                drain();
    while (live_chunks.size() != 0) begin
      issue(FUNC_FREE, 0, take_live());       drain();
    end
    issue(FUNC_ALLOC, 1048552, 0);            drain();
    issue(FUNC_ALLOC, 0, 0);                  drain();
    issue(FUNC_FREE, 0, take_live());         drain();
    issue(FUNC_ALLOC, 1048553, 0);            drain();

    // Random part: allocate and free live chunks, with a little noise in between.
    for (int i = 0; i < 1030; i++) begin
      pick = $urandom_range(99);
      if (live_chunks.size() > 30) pick = pick + 20;
      if (pick < 4) issue(FUNC_FREE, $urandom, $urandom);
      else if (pick < 60 || live_chunks.size() == 0)
        issue(FUNC_ALLOC, random_size(), $urandom);
      else issue(FUNC_FREE, $urandom, take_live());
      if (i % 250 == 125) drain();
      else idle_gap();
    end

    drain();
    repeat (300) @(posedge clk_i);
    if (fail_count == 0 && pending_count == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
